// ===== hw/rtl/mcfl_pkg.sv =====
`timescale 1ns / 1ps
package mcfl_pkg;

    // frame layout
    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;
    localparam logic [7:0]  TAIL_BYTE   = 8'h6B;

    // request codes carried in s_tuser
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RX   = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // result kinds carried in m_tuser
    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_OUTCOME = 1'b1;

    // reply outcome codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_BAD_CHECK = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_CHECK_RULE     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd2;

    // register reset values
    localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'd1;
    localparam logic        RST_CHECK_RULE     = 1'b0;
    localparam logic [31:0] RST_TIMEOUT_TICKS  = 32'd100000;

    typedef struct packed {
        logic [7:0]  device_address;
        logic        check_rule;
        logic [31:0] timeout_ticks;
    } mcfl_cfg_t;

    // one result group handed to the output stage
    typedef struct packed {
        logic                  load;
        logic                  kind;
        logic [FRAME_BITS-1:0] bytes;
        logic [1:0]            status;
        logic [7:0]            resp_status_byte;
        logic [7:0]            resp_data_byte;
    } mcfl_desc_t;

endpackage

// ===== hw/rtl/mcfl_regs.sv =====
`timescale 1ns / 1ps
module mcfl_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mcfl_pkg::mcfl_cfg_t cfg
);
    import mcfl_pkg::*;

    logic [7:0]  device_address_reg;
    logic        check_rule_reg;
    logic [31:0] timeout_ticks_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= RST_DEVICE_ADDRESS;
            check_rule_reg     <= RST_CHECK_RULE;
            timeout_ticks_reg  <= RST_TIMEOUT_TICKS;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEVICE_ADDRESS: device_address_reg <= pwdata[7:0];
                REG_CHECK_RULE:     check_rule_reg     <= pwdata[0];
                REG_TIMEOUT_TICKS:  timeout_ticks_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_DEVICE_ADDRESS: prdata = {24'd0, device_address_reg};
            REG_CHECK_RULE:     prdata = {31'd0, check_rule_reg};
            REG_TIMEOUT_TICKS:  prdata = timeout_ticks_reg;
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.device_address = device_address_reg;
    assign cfg.check_rule     = check_rule_reg;
    assign cfg.timeout_ticks  = timeout_ticks_reg;

endmodule

// ===== hw/rtl/mcfl_engine.sv =====
`timescale 1ns / 1ps
module mcfl_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command_code[7:0], data_word[39:8], expect_reply[40], rx_byte[48:41]
    input  logic [55:0]          s_tdata,
    // operation[1:0]
    input  logic [1:0]           s_tuser,
    input  mcfl_pkg::mcfl_cfg_t  cfg,
    input  logic                 out_can_load,
    output mcfl_pkg::mcfl_desc_t desc
);
    import mcfl_pkg::*;

    // input register
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [7:0]  cmd_reg;
    logic [31:0] word_reg;
    logic        expect_reg;
    logic [7:0]  rx_reg;

    // link state
    logic        awaiting_reg,  awaiting_next;
    logic [2:0]  count_reg,     count_next;
    logic [7:0]  run_chk_reg,   run_chk_next;
    logic [7:0]  rx_status_reg, rx_status_next;
    logic [7:0]  rx_data_reg,   rx_data_next;
    logic [7:0]  rx_chk_reg,    rx_chk_next;
    logic [31:0] idle_reg,      idle_next;

    logic        produces;
    logic        fire;
    logic [7:0]  frame_chk;
    logic [7:0]  hdr [6];
    logic [31:0] idle_inc;
    logic        reply_good;

    function automatic logic [7:0] fold(input logic mode, input logic [7:0] acc,
                                        input logic [7:0] b);
        return mode ? (acc ^ b) : (acc + b);
    endfunction

    // check byte over the six header and data bytes
    always_comb begin
        hdr[0] = cfg.device_address;
        hdr[1] = cmd_reg;
        hdr[2] = word_reg[7:0];
        hdr[3] = word_reg[15:8];
        hdr[4] = word_reg[23:16];
        hdr[5] = word_reg[31:24];
        frame_chk = 8'd0;
        for (int i = 0; i < 6; i++) begin
            frame_chk = fold(cfg.check_rule, frame_chk, hdr[i]);
        end
    end

    assign idle_inc   = (idle_reg != '1) ? idle_reg + 32'd1 : idle_reg;
    assign reply_good = (rx_chk_reg == run_chk_reg) && (rx_reg == TAIL_BYTE);

    // next state and result for the held request
    always_comb begin
        awaiting_next  = awaiting_reg;
        count_next     = count_reg;
        run_chk_next   = run_chk_reg;
        rx_status_next = rx_status_reg;
        rx_data_next   = rx_data_reg;
        rx_chk_next    = rx_chk_reg;
        idle_next      = idle_reg;
        produces       = 1'b0;
        desc.kind             = KIND_TX;
        desc.bytes            = '0;
        desc.status           = ST_OK;
        desc.resp_status_byte = 8'd0;
        desc.resp_data_byte   = 8'd0;
        case (op_reg)
            OP_SEND: begin
                produces      = 1'b1;
                desc.bytes    = {TAIL_BYTE, frame_chk, word_reg, cmd_reg,
                                 cfg.device_address};
                awaiting_next = expect_reg;
                count_next    = 3'd0;
                run_chk_next  = 8'd0;
                idle_next     = 32'd0;
            end
            OP_RX: begin
                if (awaiting_reg) begin
                    idle_next = 32'd0;
                    if (count_reg < 3'd6) begin
                        run_chk_next = fold(cfg.check_rule, run_chk_reg, rx_reg);
                    end
                    if (count_reg == 3'd2) rx_status_next = rx_reg;
                    if (count_reg == 3'd3) rx_data_next   = rx_reg;
                    if (count_reg == 3'd6) rx_chk_next    = rx_reg;
                    if (count_reg == 3'd7) begin
                        produces              = 1'b1;
                        desc.kind             = KIND_OUTCOME;
                        desc.status           = reply_good ? ST_OK : ST_BAD_CHECK;
                        desc.resp_status_byte = rx_status_reg;
                        desc.resp_data_byte   = rx_data_reg;
                        awaiting_next         = 1'b0;
                        count_next            = 3'd0;
                        run_chk_next          = 8'd0;
                    end else begin
                        count_next = count_reg + 3'd1;
                    end
                end
            end
            OP_TICK: begin
                if (awaiting_reg) begin
                    idle_next = idle_inc;
                    if (idle_inc >= cfg.timeout_ticks) begin
                        produces      = 1'b1;
                        desc.kind     = KIND_OUTCOME;
                        desc.status   = ST_TIMEOUT;
                        awaiting_next = 1'b0;
                        count_next    = 3'd0;
                        run_chk_next  = 8'd0;
                        idle_next     = 32'd0;
                    end
                end
            end
            default: ;
        endcase
        desc.load = in_valid_reg && produces && out_can_load;
    end

    // a request that makes no result never waits on the output stage
    assign fire      = in_valid_reg && (!produces || out_can_load);
    assign s_tready  = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg     <= s_tuser;
            cmd_reg    <= s_tdata[7:0];
            word_reg   <= s_tdata[39:8];
            expect_reg <= s_tdata[40];
            rx_reg     <= s_tdata[48:41];
        end
    end

    // link state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg  <= 1'b0;
            count_reg     <= 3'd0;
            run_chk_reg   <= 8'd0;
            rx_status_reg <= 8'd0;
            rx_data_reg   <= 8'd0;
            rx_chk_reg    <= 8'd0;
            idle_reg      <= 32'd0;
        end else if (fire) begin
            awaiting_reg  <= awaiting_next;
            count_reg     <= count_next;
            run_chk_reg   <= run_chk_next;
            rx_status_reg <= rx_status_next;
            rx_data_reg   <= rx_data_next;
            rx_chk_reg    <= rx_chk_next;
            idle_reg      <= idle_next;
        end
    end

endmodule

// ===== hw/rtl/mcfl_out.sv =====
`timescale 1ns / 1ps
module mcfl_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mcfl_pkg::mcfl_desc_t desc,
    output logic                 can_load,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tx_byte[7:0], status[9:8], resp_status_byte[17:10], resp_data_byte[25:18]
    output logic [31:0]          m_tdata,
    // kind[0]
    output logic                 m_tuser,
    output logic                 m_tlast
);
    import mcfl_pkg::*;

    localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic [FRAME_BITS-1:0] bytes_reg;
    logic                  kind_reg;
    logic [1:0]            status_reg;
    logic [7:0]            rs_reg;
    logic [7:0]            rd_reg;
    logic                  take;

    assign take     = m_tvalid && m_tready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);

    // byte counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (desc.load) begin
            cnt_reg <= (desc.kind == KIND_OUTCOME) ? CNT_W'(1) : CNT_W'(FRAME_BYTES);
        end else if (take) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // frame shift register and outcome fields
    always_ff @(posedge aclk) begin
        if (desc.load) begin
            bytes_reg  <= desc.bytes;
            kind_reg   <= desc.kind;
            status_reg <= desc.status;
            rs_reg     <= desc.resp_status_byte;
            rd_reg     <= desc.resp_data_byte;
        end else if (take) begin
            bytes_reg <= {8'd0, bytes_reg[FRAME_BITS-1:8]};
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tuser  = kind_reg;
    assign m_tlast  = (kind_reg == KIND_TX) && (cnt_reg == CNT_W'(1));
    assign m_tdata  = {6'd0, rd_reg, rs_reg, status_reg, bytes_reg[7:0]};

endmodule

// ===== hw/rtl/motor_command_frame_link_core.sv =====
`timescale 1ns / 1ps
// path: a request is held in the input register, and its first result is then registered in
// the output stage before it is offered; a busy output stage holds it in the input register
// output: a send occupies the output for its eight frame bytes, one byte per transfer, and a
// reply outcome for a single transfer; requests that make no result never wait on the output
// reset: synchronous active-low aresetn clears the link state, the output and the
// registers to address 1, byte-sum check and 100000 ticks
module motor_command_frame_link_core (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // command_code[7:0], data_word[39:8], expect_reply[40], rx_byte[48:41]
    input  logic [55:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_byte[7:0], status[9:8], resp_status_byte[17:10], resp_data_byte[25:18]
    output logic [31:0] m_tdata,
    // kind[0]
    output logic        m_tuser,
    output logic        m_tlast,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcfl_pkg::*;

    mcfl_cfg_t  cfg;
    mcfl_desc_t desc;
    logic       out_can_load;

    mcfl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcfl_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cfg          (cfg),
        .out_can_load (out_can_load),
        .desc         (desc)
    );

    mcfl_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .desc     (desc),
        .can_load (out_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/mcfl_checker.sv =====
`timescale 1ns / 1ps
module mcfl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import mcfl_pkg::*;

    // output is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // frame end only on transmit bytes and always the tail byte
    a_last_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tuser == KIND_TX) && (m_tdata[7:0] == TAIL_BYTE))
        else $error("frame end without tail byte");

    // outcome codes stay in range and carry no transmit byte
    a_outcome_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_OUTCOME) |->
            (m_tdata[9:8] != 2'd3) && (m_tdata[7:0] == 8'd0))
        else $error("malformed reply outcome");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind motor_command_frame_link_core mcfl_checker u_mcfl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== bench/tb_motor_command_frame_link_core.sv =====
`timescale 1ns / 1ps
module tb_motor_command_frame_link_core;
    import mcfl_pkg::*;

    // operation code the block does not use
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD = 400;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 44;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  cmd;
        logic [31:0] data;
        logic        want_reply;
        logic [7:0]  rx_byte;
    } link_req_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [1:0] status;
        logic [7:0] resp_status;
        logic [7:0] resp_data;
    } link_res_t;

    typedef struct {
        link_req_t req;
        bit        known;
        link_res_t typed_first;
    } script_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // command_code[7:0], data_word[39:8], expect_reply[40], rx_byte[48:41]
    logic [55:0] s_tdata = '0;
    // operation[1:0]
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // tx_byte[7:0], status[9:8], resp_status_byte[17:10], resp_data_byte[25:18]
    logic [31:0] m_tdata;
    // kind[0]
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    motor_command_frame_link_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // shadow registers
    logic [7:0]  link_addr = RST_DEVICE_ADDRESS;
    logic        link_mode = RST_CHECK_RULE;
    logic [31:0] link_timeout = RST_TIMEOUT_TICKS;

    // shadow reply state
    logic        awaiting = 1'b0;
    logic [3:0]  rx_count = '0;
    logic [7:0]  run_check = '0;
    logic [7:0]  rx_status = '0;
    logic [7:0]  rx_data = '0;
    logic [7:0]  rx_check = '0;
    logic [31:0] idle_count = '0;

    link_res_t   due_results[$];
    script_row_t script_rows[$];
    int          mismatch_count = 0;
    int          live_items = 0;
    int          burst_left = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          stall_span = 0;
    int          stall_style = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic [7:0] fold_byte(input logic [7:0] acc, input logic [7:0] b);
        return link_mode ? (acc ^ b) : (acc + b);
    endfunction

    function automatic link_res_t make_result(input logic kind, input logic [7:0] tx,
                                              input logic last, input logic [1:0] st,
                                              input logic [7:0] rs, input logic [7:0] rd);
        link_res_t res;
        res.kind = kind;
        res.tx_byte = tx;
        res.last = last;
        res.status = st;
        res.resp_status = rs;
        res.resp_data = rd;
        return res;
    endfunction

    function automatic void drop_reply();
        awaiting = 1'b0;
        rx_count = '0;
        run_check = '0;
        idle_count = '0;
    endfunction

    // frame builder and reply tracker; returns how many results were queued
    function automatic int predict_link_step(input link_req_t r);
        logic [7:0] frame [0:7];
        logic [7:0] chk;
        logic [2:0] n;
        logic [1:0] st;
        case (r.op)
            OP_SEND: begin
                frame[0] = link_addr;
                frame[1] = r.cmd;
                for (int k = 0; k < 4; k++) frame[2 + k] = r.data[8 * k +: 8];
                chk = '0;
                for (int k = 0; k < 6; k++) chk = fold_byte(chk, frame[k]);
                frame[6] = chk;
                frame[7] = TAIL_BYTE;
                for (int k = 0; k < 8; k++)
                    due_results.push_back(make_result(KIND_TX, frame[k], k == 7, ST_OK,
                                                      8'd0, 8'd0));
                drop_reply();
                awaiting = r.want_reply;
                return 8;
            end
            OP_RX: begin
                if (!awaiting) return 0;
                n = rx_count[2:0];
                idle_count = '0;
                if (n < 6) run_check = fold_byte(run_check, r.rx_byte);
                if (n == 2) rx_status = r.rx_byte;
                else if (n == 3) rx_data = r.rx_byte;
                else if (n == 6) rx_check = r.rx_byte;
                if (n == 7) begin
                    st = (rx_check == run_check && r.rx_byte == TAIL_BYTE) ? ST_OK
                                                                           : ST_BAD_CHECK;
                    due_results.push_back(make_result(KIND_OUTCOME, 8'd0, 1'b0, st,
                                                      rx_status, rx_data));
                    drop_reply();
                    return 1;
                end
                rx_count = n + 4'd1;
                return 0;
            end
            OP_TICK: begin
                if (!awaiting) return 0;
                if (idle_count != '1) idle_count++;
                if (idle_count >= link_timeout) begin
                    due_results.push_back(make_result(KIND_OUTCOME, 8'd0, 1'b0, ST_TIMEOUT,
                                                      8'd0, 8'd0));
                    drop_reply();
                    return 1;
                end
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    function automatic link_req_t random_req(input logic [1:0] op);
        link_req_t r;
        r.op = op;
        r.cmd = 8'($urandom);
        r.data = $urandom;
        r.want_reply = 1'($urandom);
        r.rx_byte = 8'($urandom);
        return r;
    endfunction

    // sender: bursts with random gaps, prediction at the accepting edge
    task automatic offer_request(input link_req_t r, input bit known,
                                 input link_res_t typed_first);
        int gap;
        int n;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= {7'd0, r.rx_byte, r.want_reply, r.data, r.cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (r.op == OP_SEND || (awaiting && (r.op == OP_RX || r.op == OP_TICK)))
            live_items++;
        n = predict_link_step(r);
        if (known && n > 0) due_results[due_results.size() - n] = typed_first;
    endtask

    // hold the sender until every result is out, then let the pipeline drain
    task automatic settle_link();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DEVICE_ADDRESS: link_addr = value[7:0];
            REG_CHECK_RULE:     link_mode = value[0];
            REG_TIMEOUT_TICKS:  link_timeout = value;
            default: ;
        endcase
    endtask

    task automatic add_row(input logic [1:0] op, input logic [7:0] cmd,
                           input logic [31:0] data, input logic want,
                           input logic [7:0] rx, input bit known, input link_res_t res);
        script_row_t row;
        row.req.op = op;
        row.req.cmd = cmd;
        row.req.data = data;
        row.req.want_reply = want;
        row.req.rx_byte = rx;
        row.known = known;
        row.typed_first = res;
        script_rows.push_back(row);
    endtask

    // one command with its reply, mostly well formed
    task automatic run_exchange();
        link_req_t r;
        logic [7:0] reply [0:7];
        logic [7:0] chk;
        int cut;
        int safe;
        r = random_req(OP_SEND);
        r.want_reply = ($urandom_range(0, 7) != 0);
        offer_request(r, 1'b0, '0);
        if (!r.want_reply) return;
        reply[0] = ($urandom_range(0, 3) != 0) ? link_addr : 8'($urandom);
        reply[1] = r.cmd;
        for (int k = 2; k < 6; k++) reply[k] = 8'($urandom);
        chk = '0;
        for (int k = 0; k < 6; k++) chk = fold_byte(chk, reply[k]);
        reply[6] = chk;
        reply[7] = TAIL_BYTE;
        // corrupt the check or the tail now and then
        case ($urandom_range(0, 9))
            0: reply[6] = reply[6] ^ (8'd1 << $urandom_range(0, 7));
            1: reply[7] = 8'($urandom);
            default: ;
        endcase
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : 8;
        safe = (link_timeout == 0) ? 0 : (link_timeout > 4 ? 3 : int'(link_timeout) - 1);
        for (int k = 0; k < cut; k++) begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(0, safe)) offer_request(random_req(OP_TICK), 1'b0, '0);
            r = random_req(OP_RX);
            r.rx_byte = reply[k];
            offer_request(r, 1'b0, '0);
        end
        // a truncated reply runs into its timeout
        if (cut < 8 && link_timeout <= 40 && $urandom_range(0, 1) == 1)
            repeat ((link_timeout == 0) ? 1 : int'(link_timeout))
                offer_request(random_req(OP_TICK), 1'b0, '0);
    endtask

    // receiver: ready pattern of its own plus one long hold on request
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_span <= $urandom_range(8, 64);
                stall_style <= $urandom_range(0, 3);
            end else begin
                stall_span <= stall_span - 1;
            end
            case (stall_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        link_res_t got;
        link_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = make_result(m_tuser, m_tdata[7:0], m_tlast, m_tdata[9:8],
                              m_tdata[17:10], m_tdata[25:18]);
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d tx %h st %0d",
                                          got.kind, got.tx_byte, got.status));
            end else begin
                want = due_results.pop_front();
                if (got.kind != want.kind || got.tx_byte != want.tx_byte ||
                    got.last != want.last || got.status != want.status ||
                    got.resp_status != want.resp_status || got.resp_data != want.resp_data)
                    report_mismatch($sformatf(
                        "got kind %0d tx %h last %0d st %0d rs %h rd %h, want %0d %h %0d %0d %h %h",
                        got.kind, got.tx_byte, got.last, got.status, got.resp_status,
                        got.resp_data, want.kind, want.tx_byte, want.last, want.status,
                        want.resp_status, want.resp_data));
            end
        end
    end

    // stimulus
    initial begin
        logic [7:0]  cfg_addr;
        logic        cfg_mode;
        logic [31:0] cfg_ticks;
        int          target;
        int          pick;
        link_req_t   r;

        // directed rows under the reset settings
        add_row(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'hFF, 1'b0, '0);
        add_row(OP_TICK, 8'h00, 32'h0, 1'b0, 8'h00, 1'b0, '0);
        add_row(OP_SEND, 8'h00, 32'h0, 1'b0, 8'h00, 1'b1,
                make_result(KIND_TX, RST_DEVICE_ADDRESS, 1'b0, ST_OK, 8'd0, 8'd0));
        add_row(OP_SEND, 8'hFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1,
                make_result(KIND_TX, RST_DEVICE_ADDRESS, 1'b0, ST_OK, 8'd0, 8'd0));
        // good reply with byte sum 7f
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h01, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'hFF, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'hA5, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h5A, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h00, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h80, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h7F, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, TAIL_BYTE, 1'b1,
                make_result(KIND_OUTCOME, 8'd0, 1'b0, ST_OK, 8'hA5, 8'h5A));
        // send while a reply is half received
        add_row(OP_SEND, 8'h12, 32'h0000_0100, 1'b1, 8'h00, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h11, 1'b0, '0);
        add_row(OP_TICK, 8'h00, 32'h0, 1'b0, 8'h00, 1'b0, '0);
        add_row(OP_SEND, 8'h34, 32'hDEAD_BEEF, 1'b1, 8'h00, 1'b0, '0);
        // reply with a good check byte 34 but a wrong tail
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h01, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h34, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'hC3, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h3C, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h00, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h00, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h34, 1'b0, '0);
        add_row(OP_RX, 8'h00, 32'h0, 1'b0, 8'h00, 1'b1,
                make_result(KIND_OUTCOME, 8'd0, 1'b0, ST_BAD_CHECK, 8'hC3, 8'h3C));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script_rows[i])
            offer_request(script_rows[i].req, script_rows[i].known, script_rows[i].typed_first);

        // random phases, each under its own register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            settle_link();
            case (ph)
                0: begin
                    cfg_addr = 8'h00;
                    cfg_mode = 1'b1;
                    cfg_ticks = 32'd0;
                end
                1: begin
                    cfg_addr = 8'hFF;
                    cfg_mode = 1'b0;
                    cfg_ticks = 32'hFFFF_FFFF;
                end
                default: begin
                    cfg_addr = 8'($urandom);
                    cfg_mode = 1'($urandom);
                    cfg_ticks = $urandom_range(1, 30);
                end
            endcase
            write_register(REG_DEVICE_ADDRESS, {24'd0, cfg_addr});
            write_register(REG_CHECK_RULE, {31'd0, cfg_mode});
            write_register(REG_TIMEOUT_TICKS, cfg_ticks);

            // long output stall while commands keep coming
            if (ph == 2) hold_requests++;

            // finish a reply left open across the settings change
            repeat ($urandom_range(0, 8)) offer_request(random_req(OP_RX), 1'b0, '0);

            target = live_items + PHASE_ITEMS;
            while (live_items < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    run_exchange();
                else if (pick < 80)
                    repeat ($urandom_range(1, 4)) offer_request(random_req(OP_TICK), 1'b0, '0);
                else if (pick < 94)
                    repeat ($urandom_range(1, 3)) offer_request(random_req(OP_RX), 1'b0, '0);
                else
                    offer_request(random_req(OP_UNUSED), 1'b0, '0);
            end

            // leave a reply half done now and then
            if ($urandom_range(0, 1) == 1) begin
                r = random_req(OP_SEND);
                r.want_reply = 1'b1;
                offer_request(r, 1'b0, '0);
                repeat ($urandom_range(1, 6)) offer_request(random_req(OP_RX), 1'b0, '0);
            end
        end

        settle_link();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mcfl_pkg.sv
hw/rtl/mcfl_regs.sv
hw/rtl/mcfl_engine.sv
hw/rtl/mcfl_out.sv
hw/rtl/motor_command_frame_link_core.sv
hw/rtl/mcfl_checker.sv
bench/tb_motor_command_frame_link_core.sv
